// ----- hw/rtl/led_driver_chain_frame_serializer_macros.svh -----
// Assertion macros used by the frame serializer sequencer.
`ifndef LED_DRIVER_CHAIN_FRAME_SERIALIZER_MACROS_SVH
`define LED_DRIVER_CHAIN_FRAME_SERIALIZER_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define LDCFS_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ldcfs assertion failed");

// Next-cycle implication, switched off while reset is high.
`define LDCFS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ldcfs assertion failed");

`endif

// ----- hw/rtl/ldcfs_pkg.sv -----
// Types, constants and helper functions of the LED driver chain frame serializer.
package ldcfs_pkg;

  localparam int MAX_CHIPS       = 8;
  localparam int DIGITS_PER_CHIP = 8;
  localparam int DEPTH           = MAX_CHIPS * DIGITS_PER_CHIP;
  localparam int CHIP_W          = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
  localparam int DIG_W           = $clog2(DIGITS_PER_CHIP);
  localparam int N_W             = $clog2(MAX_CHIPS + 1);
  localparam int ADDR_W          = $clog2(DEPTH);
  localparam int SUM_W           = DIG_W + N_W + 1;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QP_W            = $clog2(QUEUE_DEPTH);
  localparam int QC_W            = $clog2(QUEUE_DEPTH + 1);

  // Input actions.
  localparam logic [1:0] ACT_STORE   = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_REFRESH = 2'd2;
  localparam logic [1:0] ACT_CONTROL = 2'd3;

  // Queued command codes.
  localparam logic [1:0] CMD_STORE   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_REFRESH = 2'd2;
  localparam logic [1:0] CMD_CTRL    = 2'd3;

  // Control kinds.
  localparam logic [2:0] CK_DECODE    = 3'd0;
  localparam logic [2:0] CK_INTENSITY = 3'd1;
  localparam logic [2:0] CK_SCAN      = 3'd2;
  localparam logic [2:0] CK_SHUTDOWN  = 3'd3;
  localparam logic [2:0] CK_TEST      = 3'd4;

  // Driver register addresses.
  localparam logic [7:0] REG_DECODE    = 8'h09;
  localparam logic [7:0] REG_INTENSITY = 8'h0A;
  localparam logic [7:0] REG_SCAN      = 8'h0B;
  localparam logic [7:0] REG_SHUTDOWN  = 8'h0C;
  localparam logic [7:0] REG_TEST      = 8'h0F;

  localparam logic [7:0] INTENSITY_MAX = 8'd15;
  localparam logic [7:0] SCAN_MAX      = 8'd7;
  localparam logic [7:0] VAL_ONE       = 8'h01;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] device;
    logic [3:0] digit;
    logic [7:0] data;
    logic [2:0] control_kind;
  } in_item_t;

  typedef struct packed {
    logic [15:0] serial_word;
    logic        frame_end;
    logic [7:0]  read_data;
    logic        is_read_reply;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic              in_range;
    logic [7:0]        reg_addr;
    logic [7:0]        value;
  } cmd_t;

  // Effective chain length: zero acts as one, large values saturate.
  function automatic logic [N_W-1:0] eff_chain(input logic [3:0] len);
    logic [N_W-1:0] n;
    if (len == 4'd0) begin
      n = N_W'(1);
    end else if (int'(len) > MAX_CHIPS) begin
      n = N_W'(MAX_CHIPS);
    end else begin
      n = N_W'(len);
    end
    return n;
  endfunction

  // Store layout: digit-major, one row of chain_n bytes per digit.
  function automatic logic [ADDR_W-1:0] store_addr(input logic [DIG_W-1:0]  dig,
                                                   input logic [N_W-1:0]    n,
                                                   input logic [CHIP_W-1:0] dev);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(dig) * SUM_W'(n) + SUM_W'(dev);
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/ldcfs_ram.sv -----
// Generic single-port-write, registered-read RAM.
module ldcfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/ldcfs_front.sv -----
// Front end: takes input transfers, classifies them and queues commands.
module ldcfs_front (
  input  ldcfs_pkg::in_item_t         item,
  input  logic                        item_valid,
  input  logic [ldcfs_pkg::N_W-1:0]   chain_n,
  input  logic                        q_full,
  output logic                        item_ready,
  output logic                        push,
  output ldcfs_pkg::cmd_t             cmd
);

  logic       dev_ok;
  logic       dig_ok;
  logic       keep;
  logic       kind_ok;
  logic [7:0] reg_addr;
  logic [7:0] value;

  assign dev_ok = 32'(item.device) < 32'(chain_n);
  assign dig_ok = 32'(item.digit) < ldcfs_pkg::DIGITS_PER_CHIP;

  always_comb begin
    kind_ok  = 1'b1;
    reg_addr = ldcfs_pkg::REG_DECODE;
    value    = item.data;
    unique case (item.control_kind)
      ldcfs_pkg::CK_DECODE: begin
        reg_addr = ldcfs_pkg::REG_DECODE;
        value    = item.data;
      end
      ldcfs_pkg::CK_INTENSITY: begin
        reg_addr = ldcfs_pkg::REG_INTENSITY;
        value    = (item.data > ldcfs_pkg::INTENSITY_MAX) ? ldcfs_pkg::INTENSITY_MAX
                                                          : item.data;
      end
      ldcfs_pkg::CK_SCAN: begin
        reg_addr = ldcfs_pkg::REG_SCAN;
        value    = (item.data > ldcfs_pkg::SCAN_MAX) ? ldcfs_pkg::SCAN_MAX : item.data;
      end
      ldcfs_pkg::CK_SHUTDOWN: begin
        // The shutdown register is active low on the driver.
        reg_addr = ldcfs_pkg::REG_SHUTDOWN;
        value    = (item.data != 8'd0) ? 8'd0 : ldcfs_pkg::VAL_ONE;
      end
      ldcfs_pkg::CK_TEST: begin
        reg_addr = ldcfs_pkg::REG_TEST;
        value    = (item.data != 8'd0) ? ldcfs_pkg::VAL_ONE : 8'd0;
      end
      default: begin
        kind_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.addr     = ldcfs_pkg::store_addr(item.digit[ldcfs_pkg::DIG_W-1:0], chain_n,
                                         item.device[ldcfs_pkg::CHIP_W-1:0]);
    cmd.in_range = dev_ok && dig_ok;
    cmd.reg_addr = reg_addr;
    cmd.value    = item.data;
    keep         = 1'b1;
    unique case (item.action)
      ldcfs_pkg::ACT_STORE: begin
        cmd.op = ldcfs_pkg::CMD_STORE;
        keep   = dev_ok && dig_ok;
      end
      ldcfs_pkg::ACT_READ: begin
        cmd.op = ldcfs_pkg::CMD_READ;
      end
      ldcfs_pkg::ACT_REFRESH: begin
        cmd.op = ldcfs_pkg::CMD_REFRESH;
      end
      ldcfs_pkg::ACT_CONTROL: begin
        cmd.op    = ldcfs_pkg::CMD_CTRL;
        cmd.value = value;
        keep      = kind_ok;
      end
      default: begin
        cmd.op = ldcfs_pkg::CMD_READ;
      end
    endcase
  end

  // Items that cause nothing are still taken, they just never reach the queue.
  assign item_ready = !q_full;
  assign push       = item_valid && !q_full && keep;

endmodule

// ----- hw/rtl/ldcfs_cmd_fifo.sv -----
// Short command queue between the front end and the sequencer.
module ldcfs_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ldcfs_pkg::cmd_t cmd_in,
  input  logic            pop,
  output ldcfs_pkg::cmd_t head,
  output logic            full,
  output logic            empty
);

  ldcfs_pkg::cmd_t                 slots [ldcfs_pkg::QUEUE_DEPTH];
  logic [ldcfs_pkg::QP_W-1:0]      wr_ptr;
  logic [ldcfs_pkg::QP_W-1:0]      rd_ptr;
  logic [ldcfs_pkg::QC_W-1:0]      count;

  assign full  = count == ldcfs_pkg::QC_W'(ldcfs_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

endmodule

// ----- hw/rtl/ldcfs_back.sv -----
// Sequencer: runs queued commands against the frame store and drives the output register.
`include "led_driver_chain_frame_serializer_macros.svh"

module ldcfs_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ldcfs_pkg::N_W-1:0]   chain_n,
  input  logic                        q_empty,
  input  ldcfs_pkg::cmd_t             head,
  output logic                        pop,
  input  logic                        out_ready,
  output logic                        out_valid,
  output ldcfs_pkg::out_item_t        out_item
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_REFR = 2'd2;
  localparam logic [1:0] ST_CTRL = 2'd3;

  logic [1:0]                       state;
  logic [1:0]                       state_next;
  logic [ldcfs_pkg::DIG_W-1:0]      dig;
  logic [ldcfs_pkg::DIG_W-1:0]      dig_next;
  logic [ldcfs_pkg::CHIP_W-1:0]     dev;
  logic [ldcfs_pkg::CHIP_W-1:0]     dev_next;
  logic [ldcfs_pkg::CHIP_W-1:0]     last_chip;
  logic [ldcfs_pkg::N_W-1:0]        n_minus_one;
  logic [ldcfs_pkg::ADDR_W-1:0]     rd_addr;
  logic                             rd_ok;
  logic [15:0]                      ctrl_word;
  logic [ldcfs_pkg::DEPTH-1:0]      written;
  logic                             hit;
  logic [ldcfs_pkg::ADDR_W-1:0]     raddr;
  logic [7:0]                       rdata;
  logic [7:0]                       stored;
  logic                             we;
  logic                             load;
  logic                             out_free;
  logic                             frame_last;
  ldcfs_pkg::out_item_t             out_next;

  ldcfs_ram #(
    .WIDTH (8),
    .DEPTH (ldcfs_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (head.addr),
    .wdata (head.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign n_minus_one = chain_n - ldcfs_pkg::N_W'(1);
  assign last_chip   = n_minus_one[ldcfs_pkg::CHIP_W-1:0];
  assign out_free    = !out_valid || out_ready;
  // Entries never written since reset read as zero.
  assign stored      = hit ? rdata : 8'd0;
  assign frame_last  = (dev == '0) && (dig == ldcfs_pkg::DIG_W'(ldcfs_pkg::DIGITS_PER_CHIP - 1));

  always_comb begin
    state_next = state;
    dig_next   = dig;
    dev_next   = dev;
    pop        = 1'b0;
    we         = 1'b0;
    load       = 1'b0;
    out_next   = '0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          unique case (head.op)
            ldcfs_pkg::CMD_STORE: begin
              we = 1'b1;
            end
            ldcfs_pkg::CMD_READ: begin
              state_next = ST_READ;
            end
            ldcfs_pkg::CMD_REFRESH: begin
              state_next = ST_REFR;
              dig_next   = '0;
              dev_next   = last_chip;
            end
            ldcfs_pkg::CMD_CTRL: begin
              state_next = ST_CTRL;
              dev_next   = last_chip;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          load                   = 1'b1;
          out_next.read_data     = rd_ok ? stored : 8'd0;
          out_next.is_read_reply = 1'b1;
          out_next.last          = 1'b1;
          state_next             = ST_IDLE;
        end
      end
      ST_REFR: begin
        if (out_free) begin
          load                 = 1'b1;
          out_next.serial_word = {8'(dig) + 8'd1, stored};
          out_next.frame_end   = dev == '0;
          out_next.last        = frame_last;
          if (dev == '0) begin
            if (frame_last) begin
              state_next = ST_IDLE;
            end
            dig_next = dig + 1'b1;
            dev_next = last_chip;
          end else begin
            dev_next = dev - 1'b1;
          end
        end
      end
      ST_CTRL: begin
        if (out_free) begin
          load                 = 1'b1;
          out_next.serial_word = ctrl_word;
          out_next.frame_end   = dev == '0;
          out_next.last        = dev == '0;
          if (dev == '0) begin
            state_next = ST_IDLE;
          end else begin
            dev_next = dev - 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The read address follows the next word, so the registered data lines up with it.
  always_comb begin
    if (state == ST_IDLE && pop && head.op == ldcfs_pkg::CMD_READ) begin
      raddr = head.addr;
    end else if (state == ST_READ) begin
      raddr = rd_addr;
    end else begin
      raddr = ldcfs_pkg::store_addr(dig_next, chain_n, dev_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      written   <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (we) begin
        written[head.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dig <= dig_next;
    dev <= dev_next;
    hit <= written[raddr];
    if (load) begin
      out_item <= out_next;
    end
    if (pop && head.op == ldcfs_pkg::CMD_READ) begin
      rd_addr <= head.addr;
      rd_ok   <= head.in_range;
    end
    if (pop && head.op == ldcfs_pkg::CMD_CTRL) begin
      ctrl_word <= {head.reg_addr, head.value};
    end
  end

  `LDCFS_ASSERT_IMP(a_pop_only_idle, clk, rst, pop, (state == ST_IDLE) && !q_empty)
  `LDCFS_ASSERT_NEXT(a_refresh_holds, clk, rst, (state == ST_REFR) && !out_free, $stable(dig) && $stable(dev))
  `LDCFS_ASSERT_IMP(a_reply_shape, clk, rst, out_valid && out_item.is_read_reply, out_item.last && !out_item.frame_end && (out_item.serial_word == 16'd0))
  `LDCFS_ASSERT_IMP(a_last_to_idle, clk, rst, load && out_next.last, state_next == ST_IDLE)

endmodule

// ----- hw/rtl/led_driver_chain_frame_serializer.sv -----
// Top level of the LED driver chain frame serializer.
// Usage:
//   Input items arrive on in_valid/in_ready with the payload in in_item; result
//   words leave on out_valid/out_ready in out_item. cfg_wen with cfg_wdata sets
//   the chain length (0 acts as 1, above eight acts as eight).
//   A store gives no result and is written into the frame store when the
//   sequencer, while idle, takes it from the command queue. A read gives one reply.
//   A refresh gives 8*n words, one per cycle while the receiver takes them;
//   a control write gives n identical words the same way. The single read
//   port of the frame store sets the pace of one word a cycle, and the
//   sequencer takes no other command until the last word is loaded.
//   A two-entry command queue keeps taking items while the sequencer is busy;
//   in_ready drops only when that queue is full.
//   When the receiver stalls, the current word holds in the output register
//   and the sequencer waits with it.
//   Reset empties the queue and makes every frame store byte read as zero at
//   once; the chain length returns to one.
module led_driver_chain_frame_serializer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ldcfs_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ldcfs_pkg::out_item_t out_item,
  input  logic                 cfg_wen,
  input  logic [3:0]           cfg_wdata
);

  logic [3:0]                    chain_length;
  logic [ldcfs_pkg::N_W-1:0]     chain_n;
  logic                          push;
  logic                          pop;
  logic                          q_full;
  logic                          q_empty;
  ldcfs_pkg::cmd_t               cmd;
  ldcfs_pkg::cmd_t               head;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_length <= 4'd1;
    end else if (cfg_wen) begin
      chain_length <= cfg_wdata;
    end
  end

  assign chain_n = ldcfs_pkg::eff_chain(chain_length);

  ldcfs_front u_front (
    .item       (in_item),
    .item_valid (in_valid),
    .chain_n    (chain_n),
    .q_full     (q_full),
    .item_ready (in_ready),
    .push       (push),
    .cmd        (cmd)
  );

  ldcfs_cmd_fifo u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .cmd_in (cmd),
    .pop    (pop),
    .head   (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  ldcfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .chain_n   (chain_n),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
